### hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation and status codes, field widths and the command bundle passed
// from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   word_t;

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_PEEK_FRONT = 3'd4;
  localparam op_t OP_PEEK_BACK  = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } dq_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences each transfer through capture, store access and result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dq_pkg::dq_cmd_t      cmd
);
  import dq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACCESS = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_ACCESS;
      end
      S_ACCESS: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_RESULT);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.execute = (state == S_ACCESS);

endmodule

`default_nettype wire

### hw/rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring store, front pointer, entry count and the registered result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dq_pkg::dq_cmd_t   cmd,
  input  wire dq_pkg::op_t       operation,
  input  wire logic signed [31:0] data_in,
  output logic signed [31:0]     data_out,
  output dq_pkg::status_t        status,
  output logic [CW-1:0]          count,
  output logic                   is_empty
);
  import dq_pkg::*;

  localparam int SW = CW + 1;

  op_t             op_q;
  word_t           word_q;
  logic [AW-1:0]   front;
  logic [CW-1:0]   entries;
  word_t           store [DEPTH];
  word_t           rdata;
  logic            read_ok;
  status_t         status_q;

  logic [SW-1:0]   pos_sum;
  logic [SW-1:0]   last_sum;
  logic [AW-1:0]   back_in;
  logic [AW-1:0]   back_last;
  logic [AW-1:0]   front_dec;
  logic [AW-1:0]   front_inc;
  logic            full;
  logic            empty;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   front_next;
  logic [CW-1:0]   entries_next;
  status_t         status_next;
  logic            read_ok_next;

  assign pos_sum   = SW'(front) + SW'(entries);
  assign last_sum  = pos_sum - SW'(1);
  assign back_in   = (pos_sum >= SW'(DEPTH)) ? AW'(pos_sum - SW'(DEPTH)) : AW'(pos_sum);
  assign back_last = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign full      = (entries == CW'(DEPTH));
  assign empty     = (entries == '0);

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = back_in;
    rd_addr      = front;
    front_next   = front;
    entries_next = entries;
    status_next  = ST_OK;
    read_ok_next = 1'b0;
    unique case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = front_dec;
          front_next   = front_dec;
          entries_next = entries + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = back_in;
          entries_next = entries + CW'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          read_ok_next = 1'b1;
          rd_addr      = front;
          if (op_q == OP_POP_FRONT) begin
            front_next   = front_inc;
            entries_next = entries - CW'(1);
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          read_ok_next = 1'b1;
          rd_addr      = back_last;
          if (op_q == OP_POP_BACK) begin
            entries_next = entries - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      word_q <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      store[wr_addr] <= word_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      entries  <= '0;
      read_ok  <= 1'b0;
      status_q <= ST_OK;
    end else if (cmd.execute) begin
      front    <= front_next;
      entries  <= entries_next;
      read_ok  <= read_ok_next;
      status_q <= status_next;
    end
  end

  assign data_out = read_ok ? $signed(rdata) : '0;
  assign status   = status_q;
  assign count    = entries;
  assign is_empty = empty;

endmodule

`default_nettype wire

### hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded double-ended queue of signed 32-bit words held in a ring store.
// ----------------------------------------------------------------------------
// Each transfer carries one operation (push, pop or peek at either end) and
// yields exactly one result with the word read, a status, the count after the
// operation and an empty flag. An item is accepted only while the block is
// idle. The cycle after acceptance performs the single store access and
// pointer update, and the result is offered from the cycle after that. The
// result is held for as long as the output is stalled. The block is idle
// again in the cycle after the result transfer, so it takes no new item
// until the last result has been taken. Pops and peeks on an empty queue
// return status empty with a zero word; pushes on a full queue return status
// full. Nothing changes in either case.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire dq_pkg::op_t                    operation,
  input  wire logic signed [31:0]             data_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  data_out,
  output dq_pkg::status_t                     status,
  output logic [$clog2(DEPTH + 1)-1:0]        count,
  output logic                                is_empty
);
  import dq_pkg::*;

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .data_in   (data_in),
    .data_out  (data_out),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty)
  );

endmodule

`default_nettype wire

### hw/rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic signed [31:0]             data_out,
  input wire dq_pkg::status_t                status,
  input wire logic [$clog2(DEPTH + 1)-1:0]   count,
  input wire logic                           is_empty
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(count))
    else $error("Stalled result changed.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("Empty flag disagrees with count.");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == CW'(DEPTH) && data_out == '0)
    else $error("Full status without a full queue.");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> is_empty && data_out == '0)
    else $error("Empty status on a non-empty queue.");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("Result offered in the cycle after a transfer in.");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data_out  (data_out),
  .status    (status),
  .count     (count),
  .is_empty  (is_empty)
);

`default_nettype wire
